// ===== sv/sis_pkg.sv =====
// Shared types and constants for the subarray inversion weighted-sum core.
package sis_pkg;

  localparam int LEN_W   = 11;  // width of sequence_length and of item positions
  localparam int VAL_W   = 32;
  localparam int SUM_W   = 21;  // sum of positions 1..2046 fits in 21 bits
  localparam int PROD_W  = LEN_W + SUM_W;
  localparam int TOT_W   = 64;
  localparam int OUT_W   = 63;
  localparam int MAX_SEQ = 2047;  // largest length the register can express

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
  localparam logic [VAL_W-1:0] SIGN_FLIP = 32'h8000_0000;

  // Request travelling down the cell chain.
  typedef struct packed {
    logic [VAL_W-1:0] key;     // biased value: unsigned order equals signed order
    logic [LEN_W-1:0] idx;     // 0-based position within the sequence
    logic [LEN_W-1:0] weight;  // n + 1 - j
    logic             last;    // request closes its sequence
    logic [SUM_W-1:0] pos_sum; // positions of greater earlier values seen so far
  } tok_t;

endpackage

// ===== sv/sis_cell.sv =====
// One chain cell: holds one stored value and folds it into the passing request.
module sis_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          tok_vld_i,
  input  sis_pkg::tok_t tok_i,
  output logic          tok_vld_o,
  output sis_pkg::tok_t tok_o
);
  import sis_pkg::*;

  localparam logic [LEN_W-1:0] MY_IDX = LEN_W'(CELL_IDX);
  localparam logic [SUM_W-1:0] MY_POS = SUM_W'(CELL_IDX + 1);

  logic [VAL_W-1:0] val_q;
  logic             vld_q;
  tok_t             tok_d, tok_q;
  logic             hit;

  // Cells below the request's index hold earlier values of the same sequence.
  assign hit = (MY_IDX < tok_i.idx) && (val_q > tok_i.key);

  always_comb begin
    tok_d = tok_i;
    if (hit) begin
      tok_d.pos_sum = tok_i.pos_sum + MY_POS;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q <= tok_d;
    if (tok_vld_i && (tok_i.idx == MY_IDX)) begin
      val_q <= tok_i.key;
    end
  end

  assign tok_vld_o = vld_q;
  assign tok_o     = tok_q;

endmodule

// ===== sv/sis_accum.sv =====
// Weight multiply and per-sequence running total at the end of the chain.
module sis_accum (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clear_i,
  input  logic                         tok_vld_i,
  input  sis_pkg::tok_t                tok_i,
  output logic                         done_o,
  output logic [sis_pkg::OUT_W-1:0]    total_o
);
  import sis_pkg::*;

  logic              p_vld_q, p_last_q;
  logic [PROD_W-1:0] prod_q;
  logic [TOT_W-1:0]  total_d, total_q;
  logic [OUT_W-1:0]  out_q;
  logic              done_q;

  assign total_d = total_q + TOT_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_vld_q  <= 1'b0;
      p_last_q <= 1'b0;
      total_q  <= '0;
      done_q   <= 1'b0;
    end else begin
      p_vld_q  <= tok_vld_i;
      p_last_q <= tok_i.last;
      done_q   <= p_vld_q && p_last_q;
      if (clear_i) begin
        total_q <= '0;
      end else if (p_vld_q) begin
        total_q <= p_last_q ? '0 : total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(tok_i.weight) * PROD_W'(tok_i.pos_sum);
    if (p_vld_q && p_last_q) begin
      out_q <= total_d[OUT_W-1:0];
    end
  end

  assign done_o  = done_q;
  assign total_o = out_q;

endmodule

// ===== sv/subarray_inversion_weighted_sum_core.sv =====
// Top level: sequence counter, configuration register and the cell chain.
// To done_o a start passes DEPTH cells, prod_q, done_q; DEPTH = min(MAX_LEN, 2047).
// Throughput: one request per cycle; busy_o stays low, each request walks the chain
// one cell per cycle behind the previous one, and the receiver cannot stall.
// Reset: sequence_length returns to 1024, position count and running total clear;
// stored values need no clearing since a cell is written before any request reads it.
module subarray_inversion_weighted_sum_core #(
  parameter int MAX_LEN = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [sis_pkg::VAL_W-1:0]   sample_value_i,
  input  logic                               cfg_we_i,
  input  logic        [sis_pkg::LEN_W-1:0]   cfg_wdata_i,
  output logic                               done_o,
  output logic        [sis_pkg::OUT_W-1:0]   weighted_total_o
);
  import sis_pkg::*;

  localparam int DEPTH = (MAX_LEN < MAX_SEQ) ? MAX_LEN : MAX_SEQ;

  logic [LEN_W-1:0] len_q;
  logic [LEN_W-1:0] cnt_d, cnt_q;
  logic [LEN_W-1:0] n_eff;
  logic             accept;
  logic             last;

  logic tok_vld [0:DEPTH];
  tok_t tok     [0:DEPTH];

  assign busy_o = 1'b0;
  assign accept = start_i;

  always_comb begin
    if (len_q == '0) begin
      n_eff = LEN_W'(1);
    end else if (int'(len_q) > DEPTH) begin
      n_eff = LEN_W'(DEPTH);
    end else begin
      n_eff = len_q;
    end
  end

  assign last  = ((cnt_q + LEN_W'(1)) >= n_eff);
  assign cnt_d = last ? '0 : cnt_q + LEN_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_RESET;
      cnt_q <= '0;
    end else if (cfg_we_i) begin
      len_q <= cfg_wdata_i;
      cnt_q <= '0;
    end else if (accept) begin
      cnt_q <= cnt_d;
    end
  end

  always_comb begin
    tok_vld[0]     = accept;
    tok[0].key     = sample_value_i ^ SIGN_FLIP;
    tok[0].idx     = cnt_q;
    tok[0].weight  = n_eff - cnt_q;
    tok[0].last    = last;
    tok[0].pos_sum = '0;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    sis_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .tok_vld_i (tok_vld[k]),
      .tok_i     (tok[k]),
      .tok_vld_o (tok_vld[k+1]),
      .tok_o     (tok[k+1])
    );
  end

  sis_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (cfg_we_i),
    .tok_vld_i (tok_vld[DEPTH]),
    .tok_i     (tok[DEPTH]),
    .done_o    (done_o),
    .total_o   (weighted_total_o)
  );

endmodule

// ===== sim/subarray_inversion_weighted_sum_core_tb.sv =====
// Self-checking testbench for the subarray inversion weighted-sum core.
`timescale 1ns / 1ps

module subarray_inversion_weighted_sum_core_tb;
  import sis_pkg::*;

  localparam int MAX_LEN        = 1024;
  localparam int LATENCY        = MAX_LEN + 2;
  localparam int DRAIN_CYCLES   = LATENCY + 8;
  localparam int WATCHDOG_LIMIT = 8 * LATENCY;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    start_i;
  logic                    busy_o;
  logic signed [VAL_W-1:0] sample_value_i;
  logic                    cfg_we_i;
  logic [LEN_W-1:0]        cfg_wdata_i;
  logic                    done_o;
  logic [OUT_W-1:0]        weighted_total_o;

  subarray_inversion_weighted_sum_core #(
    .MAX_LEN(MAX_LEN)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .sample_value_i  (sample_value_i),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .done_o          (done_o),
    .weighted_total_o(weighted_total_o)
  );

  // Shadow of the sequence state, advanced on every accepted request.
  logic [VAL_W-1:0] seen_keys [MAX_LEN];
  int unsigned      seq_taken;
  logic [TOT_W-1:0] seq_total;
  logic [LEN_W-1:0] length_reg;

  logic [OUT_W-1:0] pending_totals [$];
  int unsigned      mismatches;
  int unsigned      stall_cycles;
  bit               sender_gaps;

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned active_length();
    int unsigned n;
    n = length_reg;
    if (n == 0) n = 1;
    if (n > MAX_LEN) n = MAX_LEN;
    return n;
  endfunction

  function automatic void predict_total(input logic signed [VAL_W-1:0] value);
    logic [VAL_W-1:0] key;
    logic [TOT_W-1:0] pos_sum;
    logic [TOT_W-1:0] weight;
    int unsigned      n;
    n = active_length();
    key = value ^ SIGN_FLIP;
    if (seq_taken >= n) begin
      seq_taken = 0;
      seq_total = '0;
    end
    pos_sum = '0;
    for (int k = 0; k < seq_taken; k++) begin
      if (seen_keys[k] > key) pos_sum += TOT_W'(k) + TOT_W'(1);
    end
    weight = TOT_W'(n) - TOT_W'(seq_taken);
    seq_total += weight * pos_sum;
    seen_keys[seq_taken] = key;
    seq_taken++;
    if (seq_taken >= n) begin
      pending_totals.push_back(seq_total[OUT_W-1:0]);
      seq_taken = 0;
      seq_total = '0;
    end
  endfunction

  function automatic logic signed [VAL_W-1:0] random_sample();
    int unsigned pick;
    pick = $urandom_range(99);
    // narrow values give many ties and short inversion runs
    if (pick < 40) return VAL_W'(int'($urandom_range(8)) - 4);
    if (pick < 55) begin
      case ($urandom_range(3))
        0: return {1'b1, {(VAL_W-1){1'b0}}};
        1: return {1'b0, {(VAL_W-1){1'b1}}};
        2: return '0;
        default: return '1;
      endcase
    end
    return $urandom();
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] error: %s", $realtime, what);
    mismatches++;
  endtask

  // Entered and left at a falling edge; start_i stays high for a back-to-back request.
  task automatic send_sample(input logic signed [VAL_W-1:0] value);
    int unsigned gap;
    gap = 0;
    if (sender_gaps && $urandom_range(99) < 30) gap = $urandom_range(1, 2);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i        <= 1'b1;
    sample_value_i <= value;
    do @(posedge clk_i); while (busy_o);
    predict_total(value);
    @(negedge clk_i);
  endtask

  task automatic drain_pipeline();
    start_i <= 1'b0;
    while (pending_totals.size() != 0) @(negedge clk_i);
    // partial sequences leave no result behind but still walk the chain
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [LEN_W-1:0] len);
    drain_pipeline();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    length_reg = len;
    seq_taken  = 0;
    seq_total  = '0;
  endtask

  task automatic send_random_sequences(input int unsigned count);
    int unsigned n;
    n = active_length();
    repeat (count * n) send_sample(random_sample());
  endtask

  task automatic test_reset_length();
    send_random_sequences(1);
  endtask

  task automatic test_length_zero_and_one();
    write_length(11'd0);
    send_sample({1'b1, {(VAL_W-1){1'b0}}});
    send_sample({1'b0, {(VAL_W-1){1'b1}}});
    send_sample('0);
    write_length(11'd1);
    send_sample(-32'sd1);
    send_sample(32'sd17);
  endtask

  task automatic test_order_extremes();
    write_length(11'd4);
    send_sample({1'b0, {(VAL_W-1){1'b1}}});
    send_sample(32'sd1);
    send_sample('0);
    send_sample({1'b1, {(VAL_W-1){1'b0}}});
    send_sample({1'b1, {(VAL_W-1){1'b0}}});
    send_sample('0);
    send_sample(32'sd1);
    send_sample({1'b0, {(VAL_W-1){1'b1}}});
  endtask

  task automatic test_equal_values();
    write_length(11'd3);
    repeat (3) send_sample(32'sd5);
  endtask

  task automatic test_write_mid_sequence();
    write_length(11'd5);
    send_sample(32'sd9);
    send_sample(32'sd7);
    send_sample(-32'sd3);
    write_length(11'd2);
    send_sample(32'sd4);
    send_sample(-32'sd4);
  endtask

  task automatic test_random_short();
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    logic [LEN_W-1:0] len;
    sent = 0;
    while (sent < 600) begin
      sender_gaps = !(sent >= 200 && sent < 350);
      pick = $urandom_range(99);
      if (pick < 5) len = '0;
      else if (pick < 75) len = LEN_W'($urandom_range(1, 8));
      else if (pick < 95) len = LEN_W'($urandom_range(9, 40));
      else len = LEN_W'($urandom_range(41, 200));
      write_length(len);
      n = active_length();
      pick = $urandom_range(1, 6);
      send_random_sequences(pick);
      sent += pick * n;
      // abandoned sequence, discarded by the next register write
      if (n > 1 && $urandom_range(9) == 0) begin
        pick = $urandom_range(1, n - 1);
        repeat (pick) send_sample(random_sample());
        sent += pick;
      end
    end
    sender_gaps = 1'b1;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (pending_totals.size() == 0) begin
        report_mismatch($sformatf("unexpected total %0d", weighted_total_o));
      end else begin
        if (weighted_total_o !== pending_totals[0]) begin
          report_mismatch($sformatf("weighted_total %0d, expected %0d",
                                    weighted_total_o, pending_totals[0]));
        end
        void'(pending_totals.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    start_i        = 1'b0;
    sample_value_i = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    length_reg     = LEN_RESET;
    seq_taken      = 0;
    seq_total      = '0;
    mismatches     = 0;
    stall_cycles   = 0;
    sender_gaps    = 1'b1;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_length();
    test_length_zero_and_one();
    test_order_extremes();
    test_equal_values();
    test_write_mid_sequence();
    test_random_short();

    drain_pipeline();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sis_pkg.sv
sv/sis_cell.sv
sv/sis_accum.sv
sv/subarray_inversion_weighted_sum_core.sv
sim/subarray_inversion_weighted_sum_core_tb.sv
